/* sv/tlik_pkg.sv */
// Shared types, constants and helpers for the two-link inverse kinematics block.
package tlik_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int ANG_FRAC     = 24;
  localparam int ANG_SH       = ANG_FRAC - FRAC_BITS;
  localparam int CORDIC_STEPS = 28;
  localparam int CD_LAT       = CORDIC_STEPS + 1;
  localparam int PRESCALE_SH  = 29;
  localparam int DIV_STEPS    = 31;
  localparam int SQRT_STEPS   = 31;
  localparam int Q_DEPTH      = 4;
  localparam int QA           = $clog2(Q_DEPTH);
  localparam int ANG_W        = 40;

  localparam logic [30:0] LINK_RESET = 31'(1 << FRAC_BITS);
  localparam logic [30:0] COS_ONE    = 31'h4000_0000;
  localparam logic [60:0] SQ_ONE     = 61'h1000_0000_0000_0000;

  localparam logic signed [ANG_W-1:0] ANG_RND   = ANG_W'((1 << ANG_SH) >> 1);
  localparam logic signed [ANG_W-1:0] ANG_HI    = ANG_W'(180) <<< FRAC_BITS;
  localparam logic signed [ANG_W-1:0] ANG_LO_SH = -(ANG_W'(180) <<< FRAC_BITS);
  localparam logic signed [ANG_W-1:0] ANG_LO_EL = '0;
  localparam logic signed [ANG_W-1:0] Z_90      = ANG_W'(90) <<< ANG_FRAC;

  typedef enum logic [0:0] {
    REG_LINK1 = 1'b0,
    REG_LINK2 = 1'b1
  } cfg_reg_t;

  // item handed from the front to the back
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [63:0]        mag;
    logic [62:0]        den;
    logic               neg;
  } fq_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [63:0]        rem;
    logic [62:0]        den;
    logic [30:0]        q;
    logic               neg;
    logic               unr;
  } dv_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [60:0]        rem;
    logic [30:0]        root;
    logic [30:0]        c;
    logic               neg;
    logic               unr;
  } sq_t;

  function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd754974720;
      1:  v = 32'd445687602;
      2:  v = 32'd235489088;
      3:  v = 32'd119537938;
      4:  v = 32'd60000934;
      5:  v = 32'd30029717;
      6:  v = 32'd15018523;
      7:  v = 32'd7509720;
      8:  v = 32'd3754917;
      9:  v = 32'd1877466;
      10: v = 32'd938734;
      11: v = 32'd469367;
      12: v = 32'd234684;
      13: v = 32'd117342;
      14: v = 32'd58671;
      15: v = 32'd29335;
      16: v = 32'd14668;
      17: v = 32'd7334;
      18: v = 32'd3667;
      19: v = 32'd1833;
      20: v = 32'd917;
      21: v = 32'd458;
      22: v = 32'd229;
      23: v = 32'd115;
      24: v = 32'd57;
      25: v = 32'd29;
      26: v = 32'd14;
      27: v = 32'd7;
      default: v = '0;
    endcase
    return ANG_W'(v);
  endfunction

  // round half up to the output fraction, then clamp
  function automatic logic signed [ANG_W-1:0] fmt_angle(input logic signed [ANG_W-1:0] a,
                                                        input logic signed [ANG_W-1:0] lo);
    logic signed [ANG_W-1:0] r;
    r = (a + ANG_RND) >>> ANG_SH;
    if (r > ANG_HI) r = ANG_HI;
    if (r < lo) r = lo;
    return r;
  endfunction

endpackage

/* sv/two_link_inverse_kinematics.sv */
// Top level of the two-link planar inverse kinematics block.
// Usage:
//   The in_ stream carries target points (x, y) in signed Q16.16; the out_
//   stream returns one item per point: shoulder angle (direction of the
//   target, -180..180 degrees) and elbow angle (0..180 degrees), both with
//   16 fraction bits, plus an unreachable flag in out_tuser.
//   Link lengths are written through cfg_ (index 0 first link, 1 second),
//   only while no item is in flight. Reset sets both to 1.0.
//   Throughput: one item per cycle while out_tready stays high. An item
//   passes 4 front stages, one queue slot, 31 divider stages, one squaring
//   stage, 31 square-root stages, 29 CORDIC stages and the output register.
//   The front and the back are parted by a 4-entry queue; the back advances
//   only while its output register is empty or being taken, so a stall on
//   out_tready stops the back, then fills the queue, and then drops in_tready.
//   No item is lost or repeated under any stall pattern.
//   Reset (rst_n low, synchronous) empties every stage and the queue.
module two_link_inverse_kinematics (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [30:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // target_x[31:0], target_y[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // shoulder_angle[24:0], elbow_angle[48:25], zeros
  output logic        out_tuser   // unreachable
);

  logic          q_full, q_push, q_empty, q_pop;
  tlik_pkg::fq_t q_din, q_dout;
  logic [24:0]   shoulder_angle;
  logic [23:0]   elbow_angle;

  tlik_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_x      (in_tdata[31:0]),
    .in_y      (in_tdata[63:32]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  tlik_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout)
  );

  tlik_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_dout       (q_dout),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_shoulder (shoulder_angle),
    .out_elbow    (elbow_angle),
    .out_unr      (out_tuser)
  );

  assign out_tdata = {7'b0, elbow_angle, shoulder_angle};

endmodule

/* sv/tlik_front.sv */
// Front: takes target points, squares and sums, classifies the cosine sign.
module tlik_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [0:0]          cfg_addr,
  input  logic [30:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic                q_full,
  output logic                q_push,
  output tlik_pkg::fq_t       q_din
);

  logic [30:0] link1_r, link2_r;

  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [31:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic [31:0]        ax1_r, ay1_r;
  logic [63:0]        axx2_r, ayy2_r;
  logic [61:0]        l1s2_r, l2s2_r, l122_r;
  logic [63:0]        d23_r;
  logic [62:0]        sa3_r, den3_r;
  tlik_pkg::fq_t      q_r;

  logic        fe_en;
  logic [31:0] ax_nxt, ay_nxt;
  logic        neg_nxt;

  assign fe_en    = !(v4_r && q_full);
  assign in_ready = fe_en;
  assign q_push   = v4_r && !q_full;
  assign q_din    = q_r;

  assign ax_nxt  = in_x[31] ? (~32'(in_x) + 32'd1) : 32'(in_x);
  assign ay_nxt  = in_y[31] ? (~32'(in_y) + 32'd1) : 32'(in_y);
  assign neg_nxt = d23_r < {1'b0, sa3_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link1_r <= tlik_pkg::LINK_RESET;
      link2_r <= tlik_pkg::LINK_RESET;
    end else if (cfg_wr_en) begin
      case (tlik_pkg::cfg_reg_t'(cfg_addr))
        tlik_pkg::REG_LINK1: link1_r <= cfg_wdata;
        tlik_pkg::REG_LINK2: link2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (fe_en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe_en) begin
      x1_r   <= in_x;
      y1_r   <= in_y;
      ax1_r  <= ax_nxt;
      ay1_r  <= ay_nxt;
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      axx2_r <= 64'(ax1_r) * 64'(ax1_r);
      ayy2_r <= 64'(ay1_r) * 64'(ay1_r);
      l1s2_r <= 62'(link1_r) * 62'(link1_r);
      l2s2_r <= 62'(link2_r) * 62'(link2_r);
      l122_r <= 62'(link1_r) * 62'(link2_r);
      x3_r   <= x2_r;
      y3_r   <= y2_r;
      d23_r  <= axx2_r + ayy2_r;
      sa3_r  <= {1'b0, l1s2_r} + {1'b0, l2s2_r};
      den3_r <= {l122_r, 1'b0};
      q_r.x   <= x3_r;
      q_r.y   <= y3_r;
      q_r.den <= den3_r;
      q_r.neg <= neg_nxt;
      q_r.mag <= neg_nxt ? ({1'b0, sa3_r} - d23_r) : (d23_r - {1'b0, sa3_r});
    end
  end

endmodule

/* sv/tlik_queue.sv */
// Short queue between front and back.
module tlik_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tlik_pkg::fq_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output tlik_pkg::fq_t dout
);

  tlik_pkg::fq_t                 mem_r [tlik_pkg::Q_DEPTH];
  logic [tlik_pkg::QA-1:0]       wp_r, rp_r;
  logic [tlik_pkg::QA:0]         cnt_r;

  assign full  = cnt_r == (tlik_pkg::QA+1)'(tlik_pkg::Q_DEPTH);
  assign empty = cnt_r == '0;
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* sv/tlik_cordic.sv */
// Pipelined vectoring CORDIC: atan2(y, x) in degrees, Q.24, one stage per iteration.
module tlik_cordic (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [32:0]                   x_in,
  input  logic signed [32:0]                   y_in,
  output logic signed [tlik_pkg::ANG_W-1:0]    z_out
);

  localparam int N = tlik_pkg::CORDIC_STEPS;

  logic signed [63:0]                cx_r [N+1];
  logic signed [63:0]                cy_r [N+1];
  logic signed [tlik_pkg::ANG_W-1:0] cz_r [N+1];
  logic                              zf_r [N+1];

  logic signed [63:0]                cx_nxt [N+1];
  logic signed [63:0]                cy_nxt [N+1];
  logic signed [tlik_pkg::ANG_W-1:0] cz_nxt [N+1];

  logic signed [63:0] xs, ys;

  assign xs = 64'({{31{x_in[32]}}, x_in}) <<< tlik_pkg::PRESCALE_SH;
  assign ys = 64'({{31{y_in[32]}}, y_in}) <<< tlik_pkg::PRESCALE_SH;

  always_comb begin
    // turn into the right half plane
    if (xs < 0) begin
      if (ys >= 0) begin
        cx_nxt[0] = ys;
        cy_nxt[0] = -xs;
        cz_nxt[0] = tlik_pkg::Z_90;
      end else begin
        cx_nxt[0] = -ys;
        cy_nxt[0] = xs;
        cz_nxt[0] = -tlik_pkg::Z_90;
      end
    end else begin
      cx_nxt[0] = xs;
      cy_nxt[0] = ys;
      cz_nxt[0] = '0;
    end
    for (int i = 0; i < N; i++) begin
      if (cy_r[i] >= 0) begin
        cx_nxt[i+1] = cx_r[i] + (cy_r[i] >>> i);
        cy_nxt[i+1] = cy_r[i] - (cx_r[i] >>> i);
        cz_nxt[i+1] = cz_r[i] + tlik_pkg::atan_deg(i);
      end else begin
        cx_nxt[i+1] = cx_r[i] - (cy_r[i] >>> i);
        cy_nxt[i+1] = cy_r[i] + (cx_r[i] >>> i);
        cz_nxt[i+1] = cz_r[i] - tlik_pkg::atan_deg(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= N; i++) begin
        cx_r[i] <= cx_nxt[i];
        cy_r[i] <= cy_nxt[i];
        cz_r[i] <= cz_nxt[i];
      end
      zf_r[0] <= (x_in == '0) && (y_in == '0);
      for (int i = 1; i <= N; i++) zf_r[i] <= zf_r[i-1];
    end
  end

  // target at the origin gives zero
  assign z_out = zf_r[N] ? '0 : cz_r[N];

endmodule

/* sv/tlik_back.sv */
// Back: cosine division, sine root, two CORDICs and the output register.
module tlik_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  tlik_pkg::fq_t q_dout,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [24:0]   out_shoulder,
  output logic [23:0]   out_elbow,
  output logic          out_unr
);

  localparam int ND = tlik_pkg::DIV_STEPS;
  localparam int NS = tlik_pkg::SQRT_STEPS;
  localparam int NC = tlik_pkg::CD_LAT;

  tlik_pkg::dv_t dv_r [ND];
  tlik_pkg::dv_t dv_nxt [ND];
  logic          dv_v_r [ND];
  tlik_pkg::sq_t sqs_r;
  logic          sqs_v_r;
  tlik_pkg::sq_t sr_r [NS];
  tlik_pkg::sq_t sr_nxt [NS];
  logic          sr_v_r [NS];
  logic          cd_v_r [NC];
  logic          cd_u_r [NC];

  logic          en;
  logic          out_valid_r, out_unr_r;
  logic [24:0]   out_sh_r;
  logic [23:0]   out_el_r;
  logic [30:0]   c_sel;
  logic signed [32:0] c_ext, sh_x, sh_y, el_x, el_y;
  logic signed [tlik_pkg::ANG_W-1:0] sh_z, el_z, sh_f, el_f;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && !q_empty;

  always_comb begin
    logic [63:0] r2;
    logic [63:0] inc;
    tlik_pkg::sq_t s;
    // first quotient bit straight from the queue head
    dv_nxt[0].x   = q_dout.x;
    dv_nxt[0].y   = q_dout.y;
    dv_nxt[0].den = q_dout.den;
    dv_nxt[0].neg = q_dout.neg;
    dv_nxt[0].unr = (q_dout.den == '0) || (q_dout.mag > {1'b0, q_dout.den});
    if (dv_nxt[0].unr) begin
      dv_nxt[0].rem = '0;
      dv_nxt[0].q   = '0;
    end else if (q_dout.mag >= {1'b0, q_dout.den}) begin
      dv_nxt[0].rem = q_dout.mag - {1'b0, q_dout.den};
      dv_nxt[0].q   = 31'd1;
    end else begin
      dv_nxt[0].rem = q_dout.mag;
      dv_nxt[0].q   = '0;
    end
    for (int i = 1; i < ND; i++) begin
      dv_nxt[i] = dv_r[i-1];
      r2 = {dv_r[i-1].rem[62:0], 1'b0};
      if (r2 >= {1'b0, dv_r[i-1].den}) begin
        dv_nxt[i].rem = r2 - {1'b0, dv_r[i-1].den};
        dv_nxt[i].q   = {dv_r[i-1].q[29:0], 1'b1};
      end else begin
        dv_nxt[i].rem = r2;
        dv_nxt[i].q   = {dv_r[i-1].q[29:0], 1'b0};
      end
    end
    // one root bit per stage, from the top
    for (int j = 0; j < NS; j++) begin
      s   = (j == 0) ? sqs_r : sr_r[j-1];
      inc = (64'(s.root) << (NS - j)) + (64'd1 << (2 * (NS - 1 - j)));
      sr_nxt[j] = s;
      if (64'(s.rem) >= inc) begin
        sr_nxt[j].rem  = 61'(64'(s.rem) - inc);
        sr_nxt[j].root = s.root | (31'd1 << (NS - 1 - j));
      end
    end
  end

  assign c_sel = dv_r[ND-1].unr ? tlik_pkg::COS_ONE : dv_r[ND-1].q;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ND; i++) dv_r[i] <= dv_nxt[i];
      sqs_r.x    <= dv_r[ND-1].x;
      sqs_r.y    <= dv_r[ND-1].y;
      sqs_r.neg  <= dv_r[ND-1].neg;
      sqs_r.unr  <= dv_r[ND-1].unr;
      sqs_r.c    <= c_sel;
      sqs_r.root <= '0;
      sqs_r.rem  <= tlik_pkg::SQ_ONE - 61'(62'(c_sel) * 62'(c_sel));
      for (int j = 0; j < NS; j++) sr_r[j] <= sr_nxt[j];
      cd_u_r[0] <= sr_r[NS-1].unr;
      for (int k = 1; k < NC; k++) cd_u_r[k] <= cd_u_r[k-1];
      out_sh_r  <= sh_f[24:0];
      out_el_r  <= el_f[23:0];
      out_unr_r <= cd_u_r[NC-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ND; i++) dv_v_r[i] <= 1'b0;
      sqs_v_r <= 1'b0;
      for (int j = 0; j < NS; j++) sr_v_r[j] <= 1'b0;
      for (int k = 0; k < NC; k++) cd_v_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= q_pop;
      for (int i = 1; i < ND; i++) dv_v_r[i] <= dv_v_r[i-1];
      sqs_v_r   <= dv_v_r[ND-1];
      sr_v_r[0] <= sqs_v_r;
      for (int j = 1; j < NS; j++) sr_v_r[j] <= sr_v_r[j-1];
      cd_v_r[0] <= sr_v_r[NS-1];
      for (int k = 1; k < NC; k++) cd_v_r[k] <= cd_v_r[k-1];
      out_valid_r <= cd_v_r[NC-1];
    end
  end

  assign sh_x  = {sr_r[NS-1].x[31], sr_r[NS-1].x};
  assign sh_y  = {sr_r[NS-1].y[31], sr_r[NS-1].y};
  assign c_ext = {2'b00, sr_r[NS-1].c};
  assign el_x  = sr_r[NS-1].neg ? -c_ext : c_ext;
  assign el_y  = {2'b00, sr_r[NS-1].root};

  tlik_cordic u_sh_cordic (
    .clk   (clk),
    .en    (en),
    .x_in  (sh_x),
    .y_in  (sh_y),
    .z_out (sh_z)
  );

  tlik_cordic u_el_cordic (
    .clk   (clk),
    .en    (en),
    .x_in  (el_x),
    .y_in  (el_y),
    .z_out (el_z)
  );

  assign sh_f = tlik_pkg::fmt_angle(sh_z, tlik_pkg::ANG_LO_SH);
  assign el_f = tlik_pkg::fmt_angle(el_z, tlik_pkg::ANG_LO_EL);

  assign out_valid    = out_valid_r;
  assign out_shoulder = out_sh_r;
  assign out_elbow    = out_el_r;
  assign out_unr      = out_unr_r;

endmodule

/* tb/sv/tb_two_link_inverse_kinematics.sv */
// Self-checking testbench for the two-link inverse kinematics block.
`timescale 1ns / 1ps

module tb_two_link_inverse_kinematics;

  localparam int LATENCY = 110;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [24:0] shoulder;
    logic [23:0] elbow;
    logic        unreach;
  } angles_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  tlik_pkg::cfg_reg_t   cfg_addr;
  logic [30:0]          cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [63:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [55:0]          out_tdata;
  logic                 out_tuser;

  two_link_inverse_kinematics dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  longint unsigned link_a, link_b;
  angles_t expected_angles[$];
  int mismatches;
  int send_idle_pct, recv_idle_pct;
  int idle_cycles;
  bit timed_out;

  // Q.24 angle table for CORDIC steps
  function automatic longint atan_entry(input int i);
    longint t[28] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                      30029717, 15018523, 7509720, 3754917, 1877466,
                      938734, 469367, 234684, 117342, 58671,
                      29335, 14668, 7334, 3667, 1833,
                      917, 458, 229, 115, 57, 29, 14, 7};
    return t[i];
  endfunction

  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint vector_angle(input longint y_in, input longint x_in);
    longint x, y, z, base, t, dx, dy;
    x = x_in; y = y_in; z = 0; base = 0;
    if (x == 0 && y == 0) return 0;
    x = x <<< 29;
    y = y <<< 29;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; base = 90;
      end else begin
        t = x; x = -y; y = t; base = -90;
      end
    end
    for (int i = 0; i < 28; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_entry(i);
      end else begin
        x -= dx; y += dy; z -= atan_entry(i);
      end
    end
    return base * (longint'(1) << 24) + z;
  endfunction

  function automatic longint round_clamp(input longint a, input longint lo_deg);
    longint hi, lo;
    hi = 180 * (longint'(1) << tlik_pkg::FRAC_BITS);
    lo = lo_deg * (longint'(1) << tlik_pkg::FRAC_BITS);
    a = floor_shr(a + (longint'(1) << (24 - tlik_pkg::FRAC_BITS - 1)),
                  24 - tlik_pkg::FRAC_BITS);
    if (a > hi) a = hi;
    if (a < lo) a = lo;
    return a;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic angles_t solve_joints(input logic signed [31:0] tx,
                                           input logic signed [31:0] ty);
    angles_t res;
    longint x, y, c, s;
    longint unsigned ax, ay, d2, sum_a, den, mag, rem, q;
    bit neg, unr;
    x = tx; y = ty;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    d2 = ax * ax + ay * ay;
    sum_a = link_a * link_a + link_b * link_b;
    den = 2 * link_a * link_b;
    neg = d2 < sum_a;
    mag = neg ? sum_a - d2 : d2 - sum_a;
    unr = 0;
    if (den == 0 || mag > den) begin
      unr = 1;
      c = longint'(1) << 30;
    end else begin
      rem = mag; q = 0;
      if (rem >= den) begin
        rem -= den; q = 1;
      end
      for (int i = 0; i < 30; i++) begin
        rem <<= 1; q <<= 1;
        if (rem >= den) begin
          rem -= den; q |= 1;
        end
      end
      c = q;
    end
    s = int_sqrt((64'd1 << 60) - longint'(c) * longint'(c));
    if (neg) c = -c;
    res.shoulder = 25'(round_clamp(vector_angle(y, x), -180));
    res.elbow = 24'(round_clamp(vector_angle(s, c), 0));
    res.unreach = unr;
    return res;
  endfunction

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result checker and receiver stall
  always @(posedge clk) begin
    angles_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_angles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item %h %b", out_tdata, out_tuser);
        end else begin
          e = expected_angles.pop_front();
          if (out_tdata[24:0] !== e.shoulder || out_tdata[48:25] !== e.elbow ||
              out_tdata[55:49] !== 7'd0 || out_tuser !== e.unreach) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp sh %h el %h unr %b, got sh %h el %h unr %b",
                       e.shoulder, e.elbow, e.unreach,
                       out_tdata[24:0], out_tdata[48:25], out_tuser);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("tb: failure");
      $finish;
    end
  end

  // tvalid stays high after an item; drop it only when idling or draining
  task automatic send_target(input logic [31:0] tx, input logic [31:0] ty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ty, tx};
    do @(posedge clk); while (!in_tready);
    expected_angles.insert(expected_angles.size(), solve_joints(tx, ty));
  endtask

  task automatic drain_pipeline();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    while (expected_angles.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_link(input tlik_pkg::cfg_reg_t idx, input logic [30:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == tlik_pkg::REG_LINK1) link_a = value;
    else link_b = value;
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(262143)) - 131072);
      2: return 32'($signed($urandom_range(8388607)) - 4194304);
      default: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
    endcase
  endfunction

  task automatic test_directed();
    send_target(32'h0, 32'h0);
    send_target(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_target(32'h8000_0000, 32'h8000_0000);
    send_target(32'h8000_0000, 32'h0);
    send_target(32'h8000_0000, 32'h7FFF_FFFF);
    send_target(32'h0, 32'h8000_0000);
    send_target(32'hFFFF_FFFF, 32'h0);
    send_target(32'h0002_0000, 32'h0);      // fully stretched, cosine +1
    send_target(32'h0, 32'h0002_0000);
    send_target(32'h0001_0000, 32'h0001_0000); // right-angle elbow
    send_target(32'h0003_0000, 32'h0);      // beyond reach
    send_target(32'hFFFF_0000, 32'hFFFF_FFFF);
    send_target(32'h0000_8000, 32'hFFFF_8000);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      // mostly reachable targets around the link lengths
      if ($urandom_range(3) != 0 && link_a + link_b < 64'h4000_0000) begin
        longint r;
        r = $urandom_range(32'(link_a + link_b));
        send_target(($urandom_range(1) ? 32'(r) : -32'(r)) ^ 32'($urandom_range(255)),
                    32'($signed($urandom_range(32'(2 * r))) - r));
      end else begin
        send_target(random_coord(), random_coord());
      end
    end
  endtask

  task automatic test_link_settings();
    write_link(tlik_pkg::REG_LINK1, 31'h0);  // zero length gives a zero denominator
    write_link(tlik_pkg::REG_LINK2, 31'h0002_0000);
    send_target(32'h0002_0000, 32'h0);
    send_target(32'h0001_0000, 32'h0);
    send_target(32'h0, 32'h0);
    test_random(20);
    drain_pipeline();
    write_link(tlik_pkg::REG_LINK1, 31'h7FFF_FFFF);
    write_link(tlik_pkg::REG_LINK2, 31'h7FFF_FFFF);
    send_target(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_target(32'h8000_0000, 32'h8000_0000);
    test_random(100);
    drain_pipeline();
    write_link(tlik_pkg::REG_LINK1, 31'h1);
    write_link(tlik_pkg::REG_LINK2, 31'h0);
    test_random(30);
    drain_pipeline();
    write_link(tlik_pkg::REG_LINK1, 31'h1);
    write_link(tlik_pkg::REG_LINK2, 31'h1);
    send_target(32'h2, 32'h0);
    send_target(32'h1, 32'h1);
    test_random(50);
    drain_pipeline();
    write_link(tlik_pkg::REG_LINK1, 31'h0003_8000);
    write_link(tlik_pkg::REG_LINK2, 31'h0001_4000);
    test_random(200);
    drain_pipeline();
    write_link(tlik_pkg::REG_LINK1, 31'($urandom));
    write_link(tlik_pkg::REG_LINK2, 31'($urandom_range(32'h0100_0000)));
    test_random(100);
    drain_pipeline();
    write_link(tlik_pkg::REG_LINK1, 31'h0001_0000);
    write_link(tlik_pkg::REG_LINK2, 31'h0001_0000);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = tlik_pkg::REG_LINK1;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    link_a = 65536;
    link_b = 65536;
    send_idle_pct = 15;
    recv_idle_pct = 49;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(480);
    drain_pipeline();
    send_idle_pct = 49;
    recv_idle_pct = 15;
    test_link_settings();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_directed();
    test_random(480);
    drain_pipeline();

    if (mismatches == 0 && expected_angles.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
